// ----- src/prit_pkg.sv -----
package prit_pkg;

  localparam int unsigned ID_W     = 64;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned COUNT_MAX = 31;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  typedef logic [TYPE_W-1:0] req_type_t;

  localparam req_type_t REQ_ALLOCATE = 3'd0;
  localparam req_type_t REQ_ADD      = 3'd1;
  localparam req_type_t REQ_LOOKUP   = 3'd2;
  localparam req_type_t REQ_TAKE     = 3'd3;
  localparam req_type_t REQ_CLEAR    = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_CLEAR,
    ST_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming request, reset sweep flags
    logic scan;    // read the entry at the pointer, advance
    logic wipe;    // write an empty entry at the pointer, advance
    logic finish;  // update state, load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_type_t req_type;
    logic      ptr_last;
    logic      out_free;
  } dp_stat_t;

endpackage

// ----- src/prit_ram.sv -----
module prit_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/prit_ctrl.sv -----
module prit_ctrl
  import prit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (stat.ptr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat.req_type) inside
          REQ_ADD, REQ_LOOKUP, REQ_TAKE: state_nxt = ST_SCAN;
          REQ_CLEAR:                     state_nxt = ST_CLEAR;
          default:                       state_nxt = ST_RESP;
        endcase
      end
      ST_SCAN: begin
        if (stat.ptr_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_RESP;
      end
      ST_CLEAR: begin
        if (stat.ptr_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_INIT:  cmd.wipe = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DECODE: ;
      ST_SCAN:  cmd.scan = 1'b1;
      ST_DRAIN: ;
      ST_CLEAR: cmd.wipe = 1'b1;
      ST_RESP:  cmd.finish = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/prit_dp.sv -----
module prit_dp
  import prit_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output dp_stat_t               stat
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned EW = ID_W + 1;

  // captured request
  req_type_t         type_r;
  logic [ID_W-1:0]   id_r;

  // sweep state
  logic [AW-1:0]     ptr_r;
  logic              rd_pend_r;
  logic [AW-1:0]     rd_idx_r;
  logic              hit_r;
  logic [AW-1:0]     hit_idx_r;
  logic              free_r;
  logic [AW-1:0]     free_idx_r;

  logic [ID_W-1:0]   next_id_r;
  logic [CW-1:0]     count_r, count_nxt;

  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // table port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [EW-1:0]     ram_wdata;
  logic [EW-1:0]     ram_rdata;

  logic              success;
  logic [ID_W-1:0]   assigned;
  logic              full;
  logic [XW-1:0]     count_x;
  logic [COUNT_W-1:0] count_sat;

  assign stat.req_type = type_r;
  assign stat.ptr_last = (ptr_r == AW'(TABLE_DEPTH - 1));
  assign stat.out_free = !out_valid_r || out_tready;

  prit_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // result of the finished sweep, plus the table write it implies or a wipe
  always_comb begin
    success   = 1'b0;
    assigned  = '0;
    full      = 1'b0;
    count_nxt = count_r;
    ram_we    = 1'b0;
    ram_addr  = ptr_r;
    ram_wdata = '0;
    if (cmd.wipe) begin
      ram_we = 1'b1;
    end
    case (type_r)
      REQ_ALLOCATE: begin
        success  = 1'b1;
        assigned = next_id_r;
      end
      REQ_ADD: begin
        if (!hit_r) begin
          if (free_r) begin
            success   = 1'b1;
            count_nxt = count_r + CW'(1);
            if (cmd.finish) begin
              ram_we    = 1'b1;
              ram_addr  = free_idx_r;
              ram_wdata = {1'b1, id_r};
            end
          end else begin
            full = 1'b1;
          end
        end
      end
      REQ_LOOKUP: success = hit_r;
      REQ_TAKE: begin
        if (hit_r) begin
          success = 1'b1;
          if (count_r != '0) count_nxt = count_r - CW'(1);
          if (cmd.finish) begin
            ram_we   = 1'b1;
            ram_addr = hit_idx_r;
          end
        end
      end
      REQ_CLEAR: begin
        success   = 1'b1;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  assign count_x   = XW'(count_nxt);
  assign count_sat = (count_x > XW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : count_x[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_tdata[TYPE_W-1:0];
      id_r   <= in_tdata[TYPE_W +: ID_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      next_id_r   <= ID_W'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan;
      if (cmd.scan || cmd.wipe) begin
        ptr_r <= stat.ptr_last ? '0 : ptr_r + AW'(1);
      end
      if (cmd.load) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (rd_pend_r) begin
        if (ram_rdata[ID_W] && ram_rdata[ID_W-1:0] == id_r && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!ram_rdata[ID_W] && !free_r) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count_r <= count_nxt;
        if (type_r == REQ_ALLOCATE) next_id_r <= next_id_r + ID_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the matching and first-free slot numbers, and load the result register
  always_ff @(posedge clk) begin
    if (cmd.scan) rd_idx_r <= ptr_r;
    if (rd_pend_r) begin
      if (ram_rdata[ID_W] && ram_rdata[ID_W-1:0] == id_r && !hit_r) hit_idx_r <= rd_idx_r;
      if (!ram_rdata[ID_W] && !free_r) free_idx_r <= rd_idx_r;
    end
    if (cmd.finish) begin
      out_data_r <= {1'b0, count_sat, full, assigned, success};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/pending_request_id_tracker.sv -----
// Operation: each accepted request is decoded; add, look up and take then scan the id
// table through its single memory port, one entry per cycle, clear wipes every entry,
// and allocate and unknown requests go straight to the result.
// Throughput: one request at a time; the next is taken once the current result is loaded.
// Reset: synchronous, active low; afterwards a wipe pass over every entry empties the table
// before the first request is taken. The id counter restarts at 1.
module pending_request_id_tracker
  import prit_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // req_type[2:0], request_id[66:3], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // success[0], assigned_id[64:1],
                                             // table_full[65], pending_count[70:66], pad
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  prit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  prit_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

endmodule
